// ----- src/rgb2hsl_pkg.sv -----
// ---------------------------------------------------------------------------
// rgb2hsl_pkg: shared constants and types of the RGB to HSL converter
// Fixed-point formats, divider geometry and pipeline depth.
// ---------------------------------------------------------------------------
package rgb2hsl_pkg;

  // Fixed-point formats of the results
  localparam int FRACTION_BITS     = 12;
  localparam int HUE_FRACTION_BITS = 6;

  localparam int CH_W   = 8;                      // one color channel
  localparam int SUM_W  = CH_W + 1;               // max + min, signed diff
  localparam int NUM_W  = CH_W + 3;               // sector offset * delta + diff
  localparam int HUE_W  = 9 + HUE_FRACTION_BITS;
  localparam int FRAC_W = FRACTION_BITS + 1;

  localparam int CH_MAX    = (1 << CH_W) - 1;
  localparam int HUE_TURN  = 360 << HUE_FRACTION_BITS;
  localparam int HUE_SCALE = 120 << HUE_FRACTION_BITS;   // 2 * 60 degrees

  // Restoring divider: quotient bits, divisor bits, bits retired per stage
  localparam int DIV_QW     = (HUE_W > FRAC_W) ? HUE_W : FRAC_W;
  localparam int DIV_DW     = CH_W + 1;
  localparam int DIV_NW     = DIV_QW + DIV_DW;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_QW + DIV_STEPS - 1) / DIV_STEPS;

  typedef logic [DIV_NW-1:0] div_num_t;
  typedef logic [DIV_DW-1:0] div_den_t;
  typedef logic [DIV_QW-1:0] div_quo_t;

endpackage

// ----- src/rgb2hsl_div.sv -----
// ---------------------------------------------------------------------------
// rgb2hsl_div: pipelined restoring divider
// Retires DIV_STEPS quotient bits per register stage; one division per cycle.
// The numerator must satisfy num_i < den_i * 2^DIV_QW.
// ---------------------------------------------------------------------------
module rgb2hsl_div (
  input  logic                  clk_i,
  input  rgb2hsl_pkg::div_num_t num_i,
  input  rgb2hsl_pkg::div_den_t den_i,
  output rgb2hsl_pkg::div_quo_t quo_o
);

  localparam int QW = rgb2hsl_pkg::DIV_QW;
  localparam int DW = rgb2hsl_pkg::DIV_DW;
  localparam int NS = rgb2hsl_pkg::DIV_STAGES;
  localparam int ST = rgb2hsl_pkg::DIV_STEPS;

  // Upper DW bits hold the partial remainder, lower QW bits the numerator
  // bits still to come, shifted out as quotient bits shift in.
  rgb2hsl_pkg::div_num_t acc_in [NS];
  rgb2hsl_pkg::div_den_t den_in [NS];
  rgb2hsl_pkg::div_num_t acc_d  [NS];
  rgb2hsl_pkg::div_num_t acc_q  [NS];
  rgb2hsl_pkg::div_den_t den_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign acc_in[s] = num_i;
      assign den_in[s] = den_i;
    end else begin : g_next
      assign acc_in[s] = acc_q[s-1];
      assign den_in[s] = den_q[s-1];
    end

    always_comb begin
      logic [DW-1:0] rem;
      logic [QW-1:0] low;
      logic [DW:0]   trial;
      rem = acc_in[s][QW+DW-1:QW];
      low = acc_in[s][QW-1:0];
      for (int k = 0; k < ST; k++) begin
        if (s * ST + k < QW) begin
          trial = {rem, low[QW-1]};
          if (trial >= {1'b0, den_in[s]}) begin
            rem = DW'(trial - {1'b0, den_in[s]});
            low = {low[QW-2:0], 1'b1};
          end else begin
            rem = trial[DW-1:0];
            low = {low[QW-2:0], 1'b0};
          end
        end
      end
      acc_d[s] = {rem, low};
    end

    always_ff @(posedge clk_i) begin
      acc_q[s] <= acc_d[s];
      den_q[s] <= den_in[s];
    end
  end

  assign quo_o = acc_q[NS-1][QW-1:0];

endmodule

// ----- src/rgb_to_hsl_converter_core.sv -----
// ---------------------------------------------------------------------------
// rgb_to_hsl_converter_core: 8-bit RGB pixel to fixed-point HSL
// Fully pipelined converter, one pixel per clock.
// ---------------------------------------------------------------------------
// Usage: drive red_i/green_i/blue_i with start high to hand over one item.
// busy is always low, so every cycle with start high is an accepted item and
// a new pixel may enter on every clock. Each item gives exactly one result,
// shown for one cycle with done_o high once the item has passed through
// every stage of the pipeline. The receiver cannot stall the block and need
// not: results leave in order at the rate items enter.
// The latency is set by the two restoring dividers (hue, saturation), each
// retiring four quotient bits per register stage over a 15-bit quotient,
// plus four stages of channel sorting and operand setup and one output
// register. Lightness divides by the constant 510 with a reciprocal
// multiplication in the operand stage and rides alongside the dividers.
// hue_o is in 1/64 degree, saturation_o and lightness_o are fractions over
// 4096; hue and saturation are rounded to nearest with halves up.
// A gray pixel (all channels equal) raises achromatic_o and forces hue and
// saturation to zero. No state is kept between items and reset needs no
// clearing pass.
// ---------------------------------------------------------------------------
module rgb_to_hsl_converter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rgb2hsl_pkg::CH_W-1:0]      red_i,
  input  logic [rgb2hsl_pkg::CH_W-1:0]      green_i,
  input  logic [rgb2hsl_pkg::CH_W-1:0]      blue_i,
  output logic                              done_o,
  output logic [rgb2hsl_pkg::HUE_W-1:0]     hue_o,
  output logic [rgb2hsl_pkg::FRAC_W-1:0]    saturation_o,
  output logic [rgb2hsl_pkg::FRAC_W-1:0]    lightness_o,
  output logic                              achromatic_o
);

  localparam int CW   = rgb2hsl_pkg::CH_W;
  localparam int SW   = rgb2hsl_pkg::SUM_W;
  localparam int NW   = rgb2hsl_pkg::NUM_W;
  localparam int HW   = rgb2hsl_pkg::HUE_W;
  localparam int FW   = rgb2hsl_pkg::FRAC_W;
  localparam int QW   = rgb2hsl_pkg::DIV_QW;
  localparam int DS   = rgb2hsl_pkg::DIV_STAGES;
  localparam int LAT  = 5 + DS;

  // Lightness is (sum * 2^(F-1) + 127) / 255: split 2^(F-1) into a whole
  // multiple of 255 and a remainder below 255
  localparam int LIT_HALF  = 1 << (rgb2hsl_pkg::FRACTION_BITS - 1);
  localparam int LIT_WHOLE = LIT_HALF / rgb2hsl_pkg::CH_MAX;
  localparam int LIT_REM   = LIT_HALF % rgb2hsl_pkg::CH_MAX;
  localparam int LZW       = 2 * CW + 1;
  localparam int LPW       = 3 * CW + 1;

  localparam logic [QW-1:0] TURN = QW'(rgb2hsl_pkg::HUE_TURN);

  // Which channel holds the maximum; red with green below blue wraps past 360
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_RED_WRAP,
    SECT_GREEN,
    SECT_BLUE
  } sect_e;

  // The pipeline never holds items off
  assign busy = 1'b0;

  // ---- Stage 1: capture the pixel ----------------------------------------
  logic          s1_vld_q;
  logic [CW-1:0] s1_r_q, s1_g_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q <= red_i;
    s1_g_q <= green_i;
    s1_b_q <= blue_i;
  end

  // ---- Stage 2: sort channels, pick the hue sector -----------------------
  logic          s2_vld_q;
  logic [CW-1:0] s2_mx_d, s2_mx_q, s2_mn_d, s2_mn_q;
  logic [SW-1:0] s2_diff_d, s2_diff_q;   // signed channel difference
  sect_e         s2_sect_d, s2_sect_q;

  always_comb begin
    priority if (s1_r_q >= s1_g_q && s1_r_q >= s1_b_q) begin
      s2_mx_d   = s1_r_q;
      s2_diff_d = {1'b0, s1_g_q} - {1'b0, s1_b_q};
      s2_sect_d = (s1_g_q < s1_b_q) ? SECT_RED_WRAP : SECT_RED;
    end else if (s1_g_q >= s1_b_q) begin
      s2_mx_d   = s1_g_q;
      s2_diff_d = {1'b0, s1_b_q} - {1'b0, s1_r_q};
      s2_sect_d = SECT_GREEN;
    end else begin
      s2_mx_d   = s1_b_q;
      s2_diff_d = {1'b0, s1_r_q} - {1'b0, s1_g_q};
      s2_sect_d = SECT_BLUE;
    end
    s2_mn_d = s1_r_q;
    if (s1_g_q < s2_mn_d) begin
      s2_mn_d = s1_g_q;
    end
    if (s1_b_q < s2_mn_d) begin
      s2_mn_d = s1_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mx_q   <= s2_mx_d;
    s2_mn_q   <= s2_mn_d;
    s2_diff_q <= s2_diff_d;
    s2_sect_q <= s2_sect_d;
  end

  // ---- Stage 3: sum, spread, saturation divisor, hue numerator -----------
  logic          s3_vld_q, s3_achro_q;
  logic [SW-1:0] s3_sum_d, s3_sum_q;
  logic [CW-1:0] s3_delta_d, s3_delta_q;
  logic [CW-1:0] s3_den_d, s3_den_q;
  logic [NW-1:0] s3_num_d, s3_num_q;
  logic [SW-1:0] s3_fold;
  logic [NW-1:0] s3_off;

  always_comb begin
    s3_sum_d   = {1'b0, s2_mx_q} + {1'b0, s2_mn_q};
    s3_delta_d = s2_mx_q - s2_mn_q;
    // Fold the upper half of the lightness range back onto the lower one
    s3_fold    = SW'(2 * rgb2hsl_pkg::CH_MAX) - s3_sum_d;
    s3_den_d   = (s3_sum_d <= SW'(rgb2hsl_pkg::CH_MAX)) ? s3_sum_d[CW-1:0]
                                                         : s3_fold[CW-1:0];
    unique case (s2_sect_q)
      SECT_RED:      s3_off = '0;
      SECT_RED_WRAP: s3_off = (NW'(s3_delta_d) << 2) + (NW'(s3_delta_d) << 1);
      SECT_GREEN:    s3_off = NW'(s3_delta_d) << 1;
      SECT_BLUE:     s3_off = NW'(s3_delta_d) << 2;
    endcase
    // Sign-extend the difference; the sum is never negative
    s3_num_d = s3_off + {{(NW-SW){s2_diff_q[SW-1]}}, s2_diff_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_achro_q <= (s2_mx_q == s2_mn_q);
    s3_sum_q   <= s3_sum_d;
    s3_delta_q <= s3_delta_d;
    s3_den_q   <= s3_den_d;
    s3_num_q   <= s3_num_d;
  end

  // ---- Stage 4: divider operands with rounding terms, lightness ----------
  logic                  s4_vld_q, s4_achro_q;
  rgb2hsl_pkg::div_num_t hue_num_q, sat_num_q;
  rgb2hsl_pkg::div_den_t hue_den_q, sat_den_q;
  logic [LZW-1:0]        lit_z;
  logic [LPW-1:0]        lit_prod;
  logic [FW-1:0]         s4_lit_d, s4_lit_q;

  // The remainder part z = sum * LIT_REM + 127 stays below 65535, and
  // floor(z / 255) is approximated by (z * 257) >> 16
  always_comb begin
    lit_z    = LZW'(s3_sum_q * LIT_REM) + LZW'((rgb2hsl_pkg::CH_MAX + 1) / 2);
    lit_prod = {lit_z, {CW{1'b0}}} + LPW'(lit_z);
    s4_lit_d = FW'(s3_sum_q * LIT_WHOLE) + FW'(lit_prod[LPW-1:2*CW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  // Each quotient is (2*x + d) / (2*d): round to nearest, halves up
  always_ff @(posedge clk_i) begin
    s4_achro_q <= s3_achro_q;
    hue_num_q  <= rgb2hsl_pkg::div_num_t'(s3_num_q)
                  * rgb2hsl_pkg::div_num_t'(rgb2hsl_pkg::HUE_SCALE)
                  + rgb2hsl_pkg::div_num_t'(s3_delta_q);
    hue_den_q  <= {s3_delta_q, 1'b0};
    sat_num_q  <= (rgb2hsl_pkg::div_num_t'(s3_delta_q) << FW)
                  + rgb2hsl_pkg::div_num_t'(s3_den_q);
    sat_den_q  <= {s3_den_q, 1'b0};
    s4_lit_q   <= s4_lit_d;
  end

  // ---- Divider stages ----------------------------------------------------
  rgb2hsl_pkg::div_quo_t hue_quo, sat_quo;

  rgb2hsl_div u_hue_div (
    .clk_i (clk_i),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue_quo)
  );

  rgb2hsl_div u_sat_div (
    .clk_i (clk_i),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat_quo)
  );

  // Carry valid, the gray flag and the lightness alongside the dividers
  logic          dly_vld_q   [DS];
  logic          dly_achro_q [DS];
  logic [FW-1:0] dly_lit_q   [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DS; i++) begin
        dly_vld_q[i] <= 1'b0;
      end
    end else begin
      dly_vld_q[0] <= s4_vld_q;
      for (int i = 1; i < DS; i++) begin
        dly_vld_q[i] <= dly_vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_achro_q[0] <= s4_achro_q;
    dly_lit_q[0]   <= s4_lit_q;
    for (int i = 1; i < DS; i++) begin
      dly_achro_q[i] <= dly_achro_q[i-1];
      dly_lit_q[i]   <= dly_lit_q[i-1];
    end
  end

  // ---- Output stage: wrap a full turn, force gray pixels -----------------
  logic          out_vld_q, out_achro_q;
  logic [HW-1:0] out_hue_d, out_hue_q;
  logic [FW-1:0] out_sat_d, out_sat_q, out_lit_q;
  logic [QW-1:0] hue_wrap;

  always_comb begin
    hue_wrap  = (hue_quo >= TURN) ? hue_quo - TURN : hue_quo;
    out_hue_d = dly_achro_q[DS-1] ? '0 : hue_wrap[HW-1:0];
    out_sat_d = dly_achro_q[DS-1] ? '0 : sat_quo[FW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dly_vld_q[DS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_achro_q <= dly_achro_q[DS-1];
    out_hue_q   <= out_hue_d;
    out_sat_q   <= out_sat_d;
    out_lit_q   <= dly_lit_q[DS-1];
  end

  assign done_o       = out_vld_q;
  assign hue_o        = out_hue_q;
  assign saturation_o = out_sat_q;
  assign lightness_o  = out_lit_q;
  assign achromatic_o = out_achro_q;

`ifndef SYNTHESIS
  // A result appears exactly the pipeline depth after an accepted item
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted item");

  // The gray flag belongs to the pixel that the result answers
  a_achro_matches_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (achromatic_o == ($past(red_i, LAT) == $past(green_i, LAT)
                                 && $past(green_i, LAT) == $past(blue_i, LAT))))
    else $error("achromatic flag does not match the pixel");

  // Hue stays below a full turn, and gray pixels carry no hue or saturation
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (QW'(hue_o) < TURN
                && (!achromatic_o || (hue_o == '0 && saturation_o == '0))))
    else $error("hue out of range or gray pixel with hue or saturation");
`endif

endmodule
